@@ rtl/hdur_pkg.sv @@
// shared types and constants for the hid descriptor usage rewriter
package hdur_pkg;

  // parser phase within one descriptor item
  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_LONG_LEN = 2'd1,
    PH_LONG_TAG = 2'd2,
    PH_DATA     = 2'd3
  } phase_t;

  localparam logic [3:0] TAG_LONG_ITEM = 4'b1111;
  localparam logic [1:0] TYPE_LOCAL    = 2'd2;
  localparam logic [7:0] USE_JOYSTICK  = 8'h04;
  localparam logic [7:0] USE_GAMEPAD   = 8'h05;
  localparam logic [7:0] USE_MULTIAXIS = 8'h08;

  // result of parsing one word
  typedef struct packed {
    logic [7:0] data;
    logic       rewritten;
    logic       truncated;
  } parse_res_t;

  // short item data length from its size code
  function automatic logic [2:0] short_size(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/hid_descriptor_usage_rewriter.sv @@
// top level: input register, item parser and result register
// an accepted input word passes through the input register and then the result register to the out_ side
// throughput: one word per cycle while out_ready stays high, set by the single parse step between the registers
// ready ripples back from out_ready through both register stages
// reset (rst_n low, synchronous) empties both stages and puts the parser
// at an item header with no pending data bytes
module hid_descriptor_usage_rewriter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_was_rewritten,
  output logic       out_truncated
);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic                 out_rew_r;
  logic                 out_trunc_r;
  logic                 s2_load;
  logic                 s1_adv;
  hdur_pkg::parse_res_t res;

  // stage advance control
  assign s2_load  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && s2_load;
  assign in_ready = !s1_valid_r || s2_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // parse step
  hdur_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .in_data (s1_byte_r),
    .in_last (s1_last_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r  <= res.data;
      out_last_r  <= s1_last_r;
      out_rew_r   <= res.rewritten;
      out_trunc_r <= res.truncated;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last          = out_last_r;
  assign out_was_rewritten = out_rew_r;
  assign out_truncated     = out_trunc_r;

  // a rewritten word always carries the multi-axis usage
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_rewritten) |-> (out_byte == hdur_pkg::USE_MULTIAXIS))
    else $error("rewritten word does not hold multi-axis usage");

  // truncation is flagged only on the final word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_truncated) |-> out_last)
    else $error("truncated flag on a non-final word");

  // a rewrite completes its item, so it never comes with truncation
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_rewritten && out_truncated))
    else $error("rewritten word flagged as truncated");

  // both stages are empty right after reset
  assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

@@ rtl/hdur_parser.sv @@
// item boundary parser state and byte rewrite logic
module hdur_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [7:0]            in_data,
  input  logic                  in_last,
  output hdur_pkg::parse_res_t  res
);

  hdur_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       left_r, left_nxt;
  logic             one_local_r, one_local_nxt;
  logic [2:0]       short_n;
  logic [7:0]       left_dec;

  assign short_n  = hdur_pkg::short_size(in_data[1:0]);
  assign left_dec = (left_r != 8'd0) ? (left_r - 8'd1) : left_r;

  // next state and output word
  always_comb begin
    phase_nxt     = phase_r;
    left_nxt      = left_r;
    one_local_nxt = one_local_r;
    res.data      = in_data;
    res.rewritten = 1'b0;
    case (phase_r)
      hdur_pkg::PH_HEADER: begin
        if (in_data[7:4] == hdur_pkg::TAG_LONG_ITEM) begin
          one_local_nxt = 1'b0;
          phase_nxt     = hdur_pkg::PH_LONG_LEN;
        end else if (short_n != 3'd0) begin
          left_nxt      = {5'd0, short_n};
          one_local_nxt = (short_n == 3'd1) && (in_data[3:2] == hdur_pkg::TYPE_LOCAL);
          phase_nxt     = hdur_pkg::PH_DATA;
        end
      end
      hdur_pkg::PH_LONG_LEN: begin
        left_nxt  = in_data;
        phase_nxt = hdur_pkg::PH_LONG_TAG;
      end
      hdur_pkg::PH_LONG_TAG: begin
        one_local_nxt = 1'b0;
        phase_nxt     = (left_r != 8'd0) ? hdur_pkg::PH_DATA : hdur_pkg::PH_HEADER;
      end
      default: begin
        if (one_local_r && (in_data == hdur_pkg::USE_JOYSTICK ||
                            in_data == hdur_pkg::USE_GAMEPAD)) begin
          res.data      = hdur_pkg::USE_MULTIAXIS;
          res.rewritten = 1'b1;
        end
        left_nxt = left_dec;
        if (left_dec == 8'd0) begin
          one_local_nxt = 1'b0;
          phase_nxt     = hdur_pkg::PH_HEADER;
        end
      end
    endcase
    res.truncated = in_last && (phase_nxt != hdur_pkg::PH_HEADER);
    // end of descriptor returns to the idle parse state
    if (in_last) begin
      phase_nxt     = hdur_pkg::PH_HEADER;
      left_nxt      = 8'd0;
      one_local_nxt = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hdur_pkg::PH_HEADER;
      left_r      <= 8'd0;
      one_local_r <= 1'b0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      left_r      <= left_nxt;
      one_local_r <= one_local_nxt;
    end
  end

endmodule
